>>> src/aat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aat_pkg: shared types and constants for the box transform core
// Fixed-point formats, payload structs, register indexes and reset values.
// ----------------------------------------------------------------------------
package aat_pkg;

  // Coordinates and translations are signed Q16.16.
  localparam int unsigned CoordW   = 32;
  // Coefficients are signed Q2.14.
  localparam int unsigned CoefW    = 16;
  localparam int unsigned CoefFrac = 14;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned RowW     = CoefW * NumAxes;
  // Full product, product after the fraction shift, and the sum of four terms.
  localparam int unsigned ProdW    = CoordW + CoefW;
  localparam int unsigned ShW      = ProdW - CoefFrac;
  localparam int unsigned SumW     = ShW + 2;
  localparam int unsigned CfgIdxW  = 3;

  // Reset values give the identity transform.
  localparam logic [RowW-1:0] Row0Reset = 48'h0000_0000_4000;
  localparam logic [RowW-1:0] Row1Reset = 48'h0000_4000_0000;
  localparam logic [RowW-1:0] Row2Reset = 48'h4000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW0     = 3'd0,
    CFG_ROW1     = 3'd1,
    CFG_ROW2     = 3'd2,
    CFG_OFFSET_X = 3'd3,
    CFG_OFFSET_Y = 3'd4,
    CFG_OFFSET_Z = 3'd5
  } cfg_idx_e;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
  } box_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_min_x;
    logic signed [CoordW-1:0] out_min_y;
    logic signed [CoordW-1:0] out_min_z;
    logic signed [CoordW-1:0] out_max_x;
    logic signed [CoordW-1:0] out_max_y;
    logic signed [CoordW-1:0] out_max_z;
    logic                     clipped;
  } box_out_t;

  // Transform as held in the register file.
  typedef struct packed {
    logic [NumAxes-1:0][RowW-1:0]   row;
    logic [NumAxes-1:0][CoordW-1:0] offset;
  } xform_t;

endpackage
`default_nettype wire

>>> src/aat_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aat_cfg_regs: transform register file
// Holds the three coefficient rows and the translation vector.
// ----------------------------------------------------------------------------
module aat_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [aat_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [aat_pkg::RowW-1:0]     cfg_data_i,
  output      aat_pkg::xform_t              xform_o
);
  import aat_pkg::*;

  xform_t xform_q, xform_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    xform_d = xform_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROW0:     xform_d.row[0]    = cfg_data_i;
        CFG_ROW1:     xform_d.row[1]    = cfg_data_i;
        CFG_ROW2:     xform_d.row[2]    = cfg_data_i;
        CFG_OFFSET_X: xform_d.offset[0] = cfg_data_i[CoordW-1:0];
        CFG_OFFSET_Y: xform_d.offset[1] = cfg_data_i[CoordW-1:0];
        CFG_OFFSET_Z: xform_d.offset[2] = cfg_data_i[CoordW-1:0];
        // Indexes past the register list are dropped.
        default:      xform_d = xform_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xform_q.row[0] <= Row0Reset;
      xform_q.row[1] <= Row1Reset;
      xform_q.row[2] <= Row2Reset;
      xform_q.offset <= '0;
    end else begin
      xform_q <= xform_d;
    end
  end

  assign xform_o = xform_q;

endmodule
`default_nettype wire

>>> src/aat_axis_bound.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aat_axis_bound: bounds of the transformed box along one output axis
// Forms both products per input axis, sorts them, sums and saturates.
// ----------------------------------------------------------------------------
module aat_axis_bound (
  input  wire logic [aat_pkg::NumAxes-1:0][aat_pkg::CoefW-1:0]  coef_i,
  input  wire logic [aat_pkg::NumAxes-1:0][aat_pkg::CoordW-1:0] lo_i,
  input  wire logic [aat_pkg::NumAxes-1:0][aat_pkg::CoordW-1:0] hi_i,
  input  wire logic [aat_pkg::CoordW-1:0]                       offset_i,
  output      aat_pkg::coord_t                                  min_o,
  output      aat_pkg::coord_t                                  max_o,
  output      logic                                             clip_o
);
  import aat_pkg::*;

  localparam logic signed [SumW-1:0] SatHi = SumW'($signed({1'b0, {(CoordW-1){1'b1}}}));
  localparam logic signed [SumW-1:0] SatLo = SumW'($signed({1'b1, {(CoordW-1){1'b0}}}));

  logic signed [ProdW-1:0] prod_a [NumAxes];
  logic signed [ProdW-1:0] prod_b [NumAxes];
  logic signed [ShW-1:0]   sh_a   [NumAxes];
  logic signed [ShW-1:0]   sh_b   [NumAxes];
  logic signed [ShW-1:0]   term_lo [NumAxes];
  logic signed [ShW-1:0]   term_hi [NumAxes];
  logic signed [SumW-1:0]  sum_lo, sum_hi;
  logic                    clip_lo, clip_hi;

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      prod_a[i] = ProdW'($signed(coef_i[i])) * ProdW'($signed(lo_i[i]));
      prod_b[i] = ProdW'($signed(hi_i[i])) * ProdW'($signed(coef_i[i]));
      // Dropping the fraction bits of a signed product rounds toward minus infinity.
      sh_a[i] = $signed(prod_a[i][ProdW-1:CoefFrac]);
      sh_b[i] = $signed(prod_b[i][ProdW-1:CoefFrac]);
      if (sh_a[i] < sh_b[i]) begin
        term_lo[i] = sh_a[i];
        term_hi[i] = sh_b[i];
      end else begin
        term_lo[i] = sh_b[i];
        term_hi[i] = sh_a[i];
      end
    end
    sum_lo = SumW'($signed(offset_i)) + SumW'(term_lo[0]) + SumW'(term_lo[1])
           + SumW'(term_lo[2]);
    sum_hi = SumW'($signed(offset_i)) + SumW'(term_hi[0]) + SumW'(term_hi[1])
           + SumW'(term_hi[2]);
  end

  always_comb begin
    clip_lo = 1'b1;
    clip_hi = 1'b1;
    if (sum_lo > SatHi) begin
      min_o = SatHi[CoordW-1:0];
    end else if (sum_lo < SatLo) begin
      min_o = SatLo[CoordW-1:0];
    end else begin
      min_o   = sum_lo[CoordW-1:0];
      clip_lo = 1'b0;
    end
    if (sum_hi > SatHi) begin
      max_o = SatHi[CoordW-1:0];
    end else if (sum_hi < SatLo) begin
      max_o = SatLo[CoordW-1:0];
    end else begin
      max_o   = sum_hi[CoordW-1:0];
      clip_hi = 1'b0;
    end
  end

  assign clip_o = clip_lo | clip_hi;

endmodule
`default_nettype wire

>>> src/aabb_affine_transform_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_affine_transform_core: axis-aligned box through an affine transform
// Gives the tight axis-aligned box around the image of each input box.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_data_i) takes one box as
//   its minimum and maximum corners per transaction. The output channel
//   (out_valid_o / out_ready_i / out_data_o) returns the transformed box and a
//   flag that is set when any bound saturated to the coordinate range.
//   The configuration channel (cfg_valid_i / cfg_ready_o / cfg_index_i /
//   cfg_data_i) writes the three coefficient rows and the translation; it is
//   always ready and must only be used while the core holds no box.
//   Flow: a box accepted at one clock edge is captured in the input
//   register, computed combinationally and loaded into the result register
//   once that register is free, and out_valid_o then rises.
//   Throughput: one box per cycle while out_ready_i is high; the only
//   combinational work per item is one 16x32 multiply per product, a compare,
//   a four-term add and the saturation, all between the input and result registers.
//   Stall: while out_ready_i is low the result register holds its box, the
//   input register still takes one more box, and in_ready_o then drops.
//   Reset: both pipeline registers empty and the transform returns to the
//   identity with zero translation.
// ----------------------------------------------------------------------------
module aabb_affine_transform_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire aat_pkg::box_in_t             in_data_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      aat_pkg::box_out_t            out_data_o,
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [aat_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [aat_pkg::RowW-1:0]     cfg_data_i
);
  import aat_pkg::*;

  xform_t xform;

  // Input stage and result stage.
  logic     in_vld_q;
  box_in_t  in_box_q;
  logic     out_vld_q;
  box_out_t out_box_q, out_box_d;

  logic out_free;
  logic in_move;

  logic [NumAxes-1:0][CoordW-1:0] lo_vec, hi_vec;
  logic [NumAxes-1:0][CoefW-1:0]  coef_col [NumAxes];
  coord_t                         bmin [NumAxes];
  coord_t                         bmax [NumAxes];
  logic [NumAxes-1:0]             clip;

  aat_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .xform_o     (xform)
  );

  // The result register is free when empty or when its box leaves this edge.
  assign out_free   = !out_vld_q || out_ready_i;
  assign in_move    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_box_q <= in_data_i;
    end
    if (in_move) begin
      out_box_q <= out_box_d;
    end
  end

  assign lo_vec = {in_box_q.min_z, in_box_q.min_y, in_box_q.min_x};
  assign hi_vec = {in_box_q.max_z, in_box_q.max_y, in_box_q.max_x};

  // Output axis j uses column j of every coefficient row.
  for (genvar j = 0; j < NumAxes; j++) begin : g_axis
    for (genvar i = 0; i < NumAxes; i++) begin : g_coef
      assign coef_col[j][i] = xform.row[i][CoefW*j +: CoefW];
    end

    aat_axis_bound u_bound (
      .coef_i   (coef_col[j]),
      .lo_i     (lo_vec),
      .hi_i     (hi_vec),
      .offset_i (xform.offset[j]),
      .min_o    (bmin[j]),
      .max_o    (bmax[j]),
      .clip_o   (clip[j])
    );
  end

  always_comb begin
    out_box_d.out_min_x = bmin[0];
    out_box_d.out_min_y = bmin[1];
    out_box_d.out_min_z = bmin[2];
    out_box_d.out_max_x = bmax[0];
    out_box_d.out_max_y = bmax[1];
    out_box_d.out_max_z = bmax[2];
    out_box_d.clipped   = |clip;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_box_q;

endmodule
`default_nettype wire
